### sv/sha_pkg.sv
// Package with the SHA-256 hasher's types, constants and round functions.
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  // Classified command passed from the front part to the back part.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       finish;
  } sha_cmd_t;

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    begin
      case (idx)
        6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  function automatic logic [31:0] initial_h(input logic [2:0] idx);
    logic [31:0] h;
    begin
      case (idx)
        3'd0: h = 32'h6a09e667;
        3'd1: h = 32'hbb67ae85;
        3'd2: h = 32'h3c6ef372;
        3'd3: h = 32'ha54ff53a;
        3'd4: h = 32'h510e527f;
        3'd5: h = 32'h9b05688c;
        3'd6: h = 32'h1f83d9ab;
        default: h = 32'h5be0cd19;
      endcase
      return h;
    end
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### sv/sha_front.sv
// Input front end: classifies transfers and queues commands for the core.
module sha_front
  import sha_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  sha_in_t  in_item,
  input  logic     in_valid,
  output logic     in_stall,
  output sha_cmd_t cmd,
  output logic     cmd_valid,
  input  logic     cmd_take
);

  localparam int Depth = 2;

  sha_cmd_t   slots [Depth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_stall  = (fill == 2'(Depth));
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slots[rd_ptr];
  // Idle transfers carry nothing and are dropped here.
  assign push = in_valid && !in_stall && (in_item.byte_valid || in_item.message_end);
  assign pop  = cmd_valid && cmd_take;

  // Two-entry queue between front and back.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{data_byte: in_item.data_byte, has_byte: in_item.byte_valid,
                         finish: in_item.message_end};
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill <= 2'(Depth))
    else $error("queue fill out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'(Depth)) |-> !push)
    else $error("push into full queue");
  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == $past(fill) + 2'd1))
    else $error("fill did not count a push");
`endif

endmodule

### sv/sha_core.sv
// Back end: block assembly, padding, 64-round compression and digest output.
module sha_core
  import sha_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  sha_cmd_t cmd,
  input  logic     cmd_valid,
  output logic     cmd_take,
  output sha_out_t out_item,
  output logic     out_valid,
  input  logic     out_stall
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_ROUND = 6'b000100,
    S_FOLD  = 6'b001000,
    S_LEN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t      state;
  logic [31:0] chain [8];
  logic [31:0] wsched [16];
  logic [31:0] ra, rb, rc, rd, re, rf, rg, rh;
  logic [60:0] count;
  logic [5:0]  round;
  logic        finishing;
  logic        padded;
  logic        len_pending;
  logic [2:0]  out_idx;

  logic [5:0]  pos;
  logic [3:0]  wi;
  logic [4:0]  sh;
  logic [60:0] count_inc;
  logic [31:0] t1, t2, s0, s1, w_new;

  assign pos       = count[5:0];
  assign wi        = pos[5:2];
  assign sh        = 5'd24 - {pos[1:0], 3'b000};
  assign count_inc = count + 61'd1;
  assign cmd_take  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_item  = '{digest_word: chain[out_idx], word_index: out_idx,
                       last_word: (out_idx == 3'd7)};

  // Round datapath and schedule extension over a 16-word window.
  always_comb begin
    t1 = rh + (ror32(re, 6) ^ ror32(re, 11) ^ ror32(re, 25)) + ((re & rf) ^ (~re & rg))
         + round_k(round) + wsched[0];
    t2 = (ror32(ra, 2) ^ ror32(ra, 13) ^ ror32(ra, 22)) + ((ra & rb) ^ (ra & rc) ^ (rb & rc));
    s0 = ror32(wsched[1], 7) ^ ror32(wsched[1], 18) ^ (wsched[1] >> 3);
    s1 = ror32(wsched[14], 17) ^ ror32(wsched[14], 19) ^ (wsched[14] >> 10);
    w_new = wsched[0] + s0 + wsched[9] + s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      round       <= '0;
      finishing   <= 1'b0;
      padded      <= 1'b0;
      len_pending <= 1'b0;
      out_idx     <= '0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= initial_h(3'(i));
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            finishing <= cmd.finish;
            if (cmd.has_byte) begin
              // Place the byte big-endian within its word.
              if (pos[1:0] == 2'd0) begin
                wsched[wi] <= {cmd.data_byte, 24'd0};
              end else begin
                wsched[wi] <= wsched[wi] | (32'(cmd.data_byte) << sh);
              end
              count <= count_inc;
              if (count_inc[5:0] == 6'd0) begin
                round <= '0;
                {ra, rb, rc, rd} <= {chain[0], chain[1], chain[2], chain[3]};
                {re, rf, rg, rh} <= {chain[4], chain[5], chain[6], chain[7]};
                state <= S_ROUND;
              end else if (cmd.finish) begin
                state <= S_PAD;
              end
            end else if (cmd.finish) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // Pad byte, zero tail, and the length when it fits in this block.
          for (int i = 0; i < 16; i++) begin
            if (4'(i) == wi) begin
              if (pos[1:0] == 2'd0) begin
                wsched[i] <= {PadByte, 24'd0};
              end else begin
                wsched[i] <= (wsched[i] & (32'hFFFFFFFF << (sh + 5'd8)))
                             | (32'(PadByte) << sh);
              end
            end else if (4'(i) > wi) begin
              if (pos < 6'd56 && i == 14) begin
                wsched[i] <= count[60:29];
              end else if (pos < 6'd56 && i == 15) begin
                wsched[i] <= {count[28:0], 3'b000};
              end else begin
                wsched[i] <= '0;
              end
            end
          end
          len_pending <= (pos >= 6'd56);
          padded <= 1'b1;
          round <= '0;
          {ra, rb, rc, rd} <= {chain[0], chain[1], chain[2], chain[3]};
          {re, rf, rg, rh} <= {chain[4], chain[5], chain[6], chain[7]};
          state <= S_ROUND;
        end
        S_ROUND: begin
          {rb, rc, rd} <= {ra, rb, rc};
          {rf, rg, rh} <= {re, rf, rg};
          ra <= t1 + t2;
          re <= rd + t1;
          for (int i = 0; i < 15; i++) begin
            wsched[i] <= wsched[i+1];
          end
          wsched[15] <= w_new;
          round <= round + 6'd1;
          if (round == 6'd63) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          chain[0] <= chain[0] + ra; chain[1] <= chain[1] + rb;
          chain[2] <= chain[2] + rc; chain[3] <= chain[3] + rd;
          chain[4] <= chain[4] + re; chain[5] <= chain[5] + rf;
          chain[6] <= chain[6] + rg; chain[7] <= chain[7] + rh;
          // A message that ends on a full block still needs its padding block.
          if (!finishing) begin
            state <= S_IDLE;
          end else if (!padded) begin
            state <= S_PAD;
          end else if (len_pending) begin
            state <= S_LEN;
          end else begin
            state <= S_OUT;
          end
        end
        S_LEN: begin
          // Extra block holding only zeros and the bit length.
          for (int i = 0; i < 14; i++) begin
            wsched[i] <= '0;
          end
          wsched[14] <= {count[60:29]};
          wsched[15] <= {count[28:0], 3'b000};
          len_pending <= 1'b0;
          round <= '0;
          {ra, rb, rc, rd} <= {chain[0], chain[1], chain[2], chain[3]};
          {re, rf, rg, rh} <= {chain[4], chain[5], chain[6], chain[7]};
          state <= S_ROUND;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                chain[i] <= initial_h(3'(i));
              end
              count     <= '0;
              finishing <= 1'b0;
              padded    <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_idx)))
    else $error("digest word moved while stalled");
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && round == 6'd63) |=> (state == S_FOLD))
    else $error("round loop did not end in fold");
  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (out_idx == 3'd0))
    else $error("word index not cleared");
`endif

endmodule

### sv/sha256_stream_hasher.sv
// Top level of the streaming SHA-256 hasher: front queue and compression core.
//
//   channel | direction | payload   | handshake
//   in      | input     | sha_in_t  | in_valid / in_stall
//   out     | output    | sha_out_t | out_valid / out_stall
//
// A byte transfer that does not fill a block is placed into it while the core is idle.
// A full block runs the round loop and then a fold; an end transfer adds a pad
// step, one or two compressions (a second one needs one more set-up state)
// and eight digest words, each of which waits while out_stall is high.
// The two-entry queue accepts while the core rounds or waits, until it fills.
// Reset restores the initial hash values and a zero byte count.
module sha256_stream_hasher
  import sha_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  sha_in_t  in_item,
  input  logic     in_valid,
  output logic     in_stall,
  output sha_out_t out_item,
  output logic     out_valid,
  input  logic     out_stall
);

  sha_cmd_t cmd;
  logic     cmd_valid;
  logic     cmd_take;

  sha_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take)
  );

  sha_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

endmodule
